// ----- rtl/core/frx_pkg.sv -----
// Shared types and codes for the frame receiver with XOR check.
`default_nettype none

package frx_pkg;

	// Receive phase of the deframer.
	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_LEN   = 3'd1,
		PH_DATA  = 3'd2,
		PH_CHECK = 3'd3,
		PH_END   = 3'd4
	} phase_t;

	// Kind of result item.
	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	// Frame status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_END = 2'd1,
		ST_BAD_SUM = 2'd2
	} status_t;

	// Configuration register indexes.
	localparam logic CFG_START_MARKER = 1'b0;
	localparam logic CFG_END_MARKER   = 1'b1;

	// Reset values of the marker registers.
	localparam logic [7:0] START_MARKER_RST = 8'd170;
	localparam logic [7:0] END_MARKER_RST   = 8'd85;

	// One result item as it travels to the output register.
	typedef struct packed {
		kind_t      result_kind;
		logic [7:0] payload_byte;
		status_t    frame_status;
	} frx_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/frx_in_stage.sv -----
// Input register stage: holds one received byte until the parser takes it.
`default_nettype none

module frx_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            in_ready,
	output logic            valid_s1,
	output logic [7:0]      rx_byte_s1
);
	import frx_pkg::*;

	// The stage is free when empty or when its item moves on this cycle.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Byte held in the stage.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/frx_parser.sv -----
// Frame parser: phase machine, length count and running XOR.
`default_nettype none

module frx_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   rx_byte_s1,
	input  wire logic [7:0]   start_marker,
	input  wire logic [7:0]   end_marker,
	output logic              res_valid,
	output frx_pkg::frx_result_t res
);
	import frx_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] running_xor_q, running_xor_d;
	logic [7:0] received_check_q, received_check_d;

	// Phase and frame state registers, updated when a byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HUNT;
			remaining_q      <= '0;
			running_xor_q    <= '0;
			received_check_q <= '0;
		end else if (step) begin
			phase_q          <= phase_d;
			remaining_q      <= remaining_d;
			running_xor_q    <= running_xor_d;
			received_check_q <= received_check_d;
		end
	end

	// Next state and result for the byte in the input stage.
	always_comb begin
		phase_d          = phase_q;
		remaining_d      = remaining_q;
		running_xor_d    = running_xor_q;
		received_check_d = received_check_q;
		res_valid        = 1'b0;
		res.result_kind  = KIND_PAYLOAD;
		res.payload_byte = '0;
		res.frame_status = ST_OK;
		case (phase_q)
			PH_LEN: begin
				remaining_d   = rx_byte_s1;
				running_xor_d = '0;
				phase_d       = (rx_byte_s1 == 8'd0) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				running_xor_d    = running_xor_q ^ rx_byte_s1;
				remaining_d      = remaining_q - 8'd1;
				if (remaining_d == 8'd0) begin
					phase_d = PH_CHECK;
				end
				res_valid        = 1'b1;
				res.payload_byte = rx_byte_s1;
			end
			PH_CHECK: begin
				received_check_d = rx_byte_s1;
				phase_d          = PH_END;
			end
			PH_END: begin
				res_valid       = 1'b1;
				res.result_kind = KIND_STATUS;
				if (rx_byte_s1 != end_marker) begin
					res.frame_status = ST_BAD_END;
				end else if (received_check_q != running_xor_q) begin
					res.frame_status = ST_BAD_SUM;
				end else begin
					res.frame_status = ST_OK;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				// Hunting: everything but the start marker is dropped.
				phase_d = (rx_byte_s1 == start_marker) ? PH_LEN : PH_HUNT;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/frx_out_stage.sv -----
// Result register: holds one result item until the consumer takes it.
`default_nettype none

module frx_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire frx_pkg::frx_result_t res,
	input  wire logic                 out_ready,
	output logic                      out_free,
	output logic                      out_valid,
	output frx_pkg::frx_result_t      res_q
);
	import frx_pkg::*;

	// A new item may be loaded when empty or when the held item leaves now.
	assign out_free = !out_valid || out_ready;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/frame_receiver_xor_check.sv -----
// Top level of the frame receiver with XOR check.
// A byte is registered in the input stage and its result item in the result register.
// Throughput: one byte per cycle while the result side keeps taking items.
// The input register and the result register each hold one item.
// Reset (arst_n low) clears the phase to hunting, the count, XOR and
// checksum to zero, and sets the start and end markers to 170 and 85.
`default_nettype none

module frame_receiver_xor_check (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            result_kind,
	output logic [7:0]      payload_byte,
	output logic [1:0]      frame_status
);
	import frx_pkg::*;

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        step;
	logic        res_valid;
	logic        out_free;
	frx_result_t res;
	frx_result_t res_q;
	logic [7:0]  start_marker_q;
	logic [7:0]  end_marker_q;

	// Marker registers written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held byte is consumed unless it makes a result that cannot be stored.
	assign step = valid_s1 && (!res_valid || out_free);

	frx_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.rx_byte    (rx_byte),
		.advance    (step),
		.in_ready   (in_ready),
		.valid_s1   (valid_s1),
		.rx_byte_s1 (rx_byte_s1)
	);

	frx_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte_s1   (rx_byte_s1),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	frx_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	// Result fields to the ports.
	assign result_kind  = res_q.result_kind;
	assign payload_byte = res_q.payload_byte;
	assign frame_status = res_q.frame_status;

`ifndef SYNTH
	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid) |-> (!out_valid || out_ready))
		else $error("result loaded over a waiting item");

	// A stalled input stage always holds an item.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled while empty");

	// Payload items carry status ok.
	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_PAYLOAD) |-> (frame_status == ST_OK))
		else $error("payload item with non-ok status");

	// Status items carry a zero payload byte.
	a_status_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_STATUS) |-> (payload_byte == 8'd0))
		else $error("status item with non-zero byte");
`endif

endmodule

`default_nettype wire

// ----- test/frame_receiver_xor_check_tb.sv -----
// Self-checking testbench for the frame receiver with XOR check.
`timescale 1ns / 1ps

module frame_receiver_xor_check_tb;
	import frx_pkg::*;

	localparam int ITEM_TARGET = 550;
	localparam int QUIET_TAIL  = 100;

	// Tracks the deframer state and holds the result items still owed by the block.
	class frame_scoreboard;
		logic [7:0]  start_mark;
		logic [7:0]  end_mark;
		phase_t      rx_phase;
		logic [7:0]  remaining;
		logic [7:0]  xor_acc;
		logic [7:0]  check_byte;
		frx_result_t owed_q[$];
		int          errors;

		function new();
			start_mark = START_MARKER_RST;
			end_mark   = END_MARKER_RST;
			rx_phase   = PH_HUNT;
			remaining  = '0;
			xor_acc    = '0;
			check_byte = '0;
			errors     = 0;
		endfunction

		function void set_marker(logic idx, logic [7:0] value);
			if (idx == CFG_START_MARKER) begin
				start_mark = value;
			end else begin
				end_mark = value;
			end
		endfunction

		// Advances the deframer by one accepted item and records any result it causes.
		function void note_byte(logic [7:0] b);
			frx_result_t r;
			r.result_kind  = KIND_PAYLOAD;
			r.payload_byte = '0;
			r.frame_status = ST_OK;
			case (rx_phase)
				PH_LEN: begin
					remaining = b;
					xor_acc   = '0;
					rx_phase  = (b == 8'd0) ? PH_CHECK : PH_DATA;
				end
				PH_DATA: begin
					xor_acc   = xor_acc ^ b;
					remaining = remaining - 8'd1;
					if (remaining == 8'd0) begin
						rx_phase = PH_CHECK;
					end
					r.payload_byte = b;
					owed_q = {owed_q, r};
				end
				PH_CHECK: begin
					check_byte = b;
					rx_phase   = PH_END;
				end
				PH_END: begin
					r.result_kind = KIND_STATUS;
					if (b != end_mark) begin
						r.frame_status = ST_BAD_END;
					end else if (check_byte != xor_acc) begin
						r.frame_status = ST_BAD_SUM;
					end
					rx_phase = PH_HUNT;
					owed_q = {owed_q, r};
				end
				default: begin
					rx_phase = (b == start_mark) ? PH_LEN : PH_HUNT;
				end
			endcase
		endfunction

		// Compares one delivered result item with the oldest one owed.
		function void check_result(logic kind, logic [7:0] pb, logic [1:0] st);
			frx_result_t r;
			if (owed_q.size() == 0) begin
				$error("unexpected result item: kind %0d byte %0d status %0d",
					kind, pb, st);
				errors++;
				return;
			end
			r = owed_q.pop_front();
			if (kind !== r.result_kind) begin
				$error("result_kind: expected %0d, got %0d", r.result_kind, kind);
				errors++;
			end
			if (pb !== r.payload_byte) begin
				$error("payload_byte: expected %0d, got %0d", r.payload_byte, pb);
				errors++;
			end
			if (st !== r.frame_status) begin
				$error("frame_status: expected %0d, got %0d", r.frame_status, st);
				errors++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [1:0] frame_status;

	frame_scoreboard frames;
	int              sent;
	bit              quiet;
	logic [7:0]      cur_start;
	logic [7:0]      cur_end;

	frame_receiver_xor_check dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.frame_status (frame_status)
	);

	// 100 MHz clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Guard against a hung handshake.
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Result side: random stall bursts until the quiet tail of the run.
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Every accepted result item is checked at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			frames.check_result(result_kind, payload_byte, frame_status);
		end
	end

	// Offers one item, with an optional gap before it, and waits until it is taken.
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		frames.note_byte(b);
		sent++;
		@(negedge clk);
	endtask

	// Holds the input side until every owed result is out and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (frames.pending() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Writes both marker registers on consecutive cycles while the block is idle.
	task automatic write_markers(input logic [7:0] s, input logic [7:0] e);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_MARKER;
		cfg_data  <= s;
		@(negedge clk);
		cfg_index <= CFG_END_MARKER;
		cfg_data  <= e;
		@(negedge clk);
		cfg_we <= 1'b0;
		frames.set_marker(CFG_START_MARKER, s);
		frames.set_marker(CFG_END_MARKER, e);
		cur_start = s;
		cur_end   = e;
		@(negedge clk);
	endtask

	// One frame with random content; the checksum and end item may be spoilt on request.
	task automatic send_frame(input int len, input bit bad_sum, input bit bad_end);
		logic [7:0] acc;
		logic [7:0] b;
		acc = '0;
		send_byte(cur_start);
		send_byte(len[7:0]);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			acc ^= b;
			send_byte(b);
		end
		send_byte(bad_sum ? acc ^ 8'($urandom_range(1, 255)) : acc);
		send_byte(bad_end ? cur_end ^ 8'($urandom_range(1, 255)) : cur_end);
	endtask

	// Mostly well-formed frames, with noise, cut-off frames and occasional drains mixed in.
	task automatic random_traffic(input int until_count);
		int pick;
		int len;
		while (sent < until_count) begin
			quiet = (sent >= ITEM_TARGET - QUIET_TAIL);
			pick  = $urandom_range(0, 99);
			len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			if (pick < 78) begin
				send_frame(len, $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 98) begin
				// Cut-off frame: whatever follows lands in its later positions.
				send_byte(cur_start);
				send_byte(len[7:0]);
				repeat ($urandom_range(0, len)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				drain();
			end
		end
	endtask

	initial begin
		frames    = new();
		sent      = 0;
		quiet     = 1'b0;
		cur_start = START_MARKER_RST;
		cur_end   = END_MARKER_RST;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_START_MARKER;
		cfg_data  = '0;
		in_valid  = 1'b0;
		rx_byte   = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under the reset markers.
		send_byte(8'h00);
		send_byte(8'hFF);
		// Zero length, checksum right.
		send_byte(8'hAA); send_byte(8'h00); send_byte(8'h00); send_byte(8'h55);
		// Zero length, checksum wrong.
		send_byte(8'hAA); send_byte(8'h00); send_byte(8'h07); send_byte(8'h55);
		// Payload extremes, all good.
		send_byte(8'hAA); send_byte(8'h02); send_byte(8'hFF); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'h55);
		// Start marker as payload, then both a wrong checksum and a wrong end item.
		send_byte(8'hAA); send_byte(8'h01); send_byte(8'hAA); send_byte(8'h00);
		send_byte(8'h00);
		// End marker in the payload, checksum and end positions.
		send_byte(8'hAA); send_byte(8'h01); send_byte(8'h55); send_byte(8'h55);
		send_byte(8'h55);

		// Reset markers, then the extremes, then random settings.
		random_traffic(140);
		drain();
		write_markers(8'h00, 8'hFF);
		send_frame(255, 1'b0, 1'b0);
		random_traffic(390);
		drain();
		write_markers(8'hFF, 8'h00);
		random_traffic(440);
		drain();
		write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_traffic(ITEM_TARGET);

		drain();
		repeat (10) @(negedge clk);
		if (frames.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/frx_pkg.sv
rtl/core/frx_in_stage.sv
rtl/core/frx_parser.sv
rtl/core/frx_out_stage.sv
rtl/core/frame_receiver_xor_check.sv
test/frame_receiver_xor_check_tb.sv
